>>> hdl/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg
// Types, character codes and helper functions shared by the serial command
// line decoder modules.
// ----------------------------------------------------------------------------
package scld_pkg;

    // console characters
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [30:0] SAT_VALUE = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_CMD0,
        S_CMD1,
        S_SKIP,
        S_ZERO,
        S_PREFIX,
        S_DIGIT
    } state_t;

    typedef enum logic [3:0] {
        RES_PROMPT       = 4'd0,
        RES_TOO_LONG     = 4'd1,
        RES_HELP         = 4'd2,
        RES_SEND         = 4'd3,
        RES_RELAY_ON     = 4'd4,
        RES_RELAY_OFF    = 4'd5,
        RES_ALL_OFF      = 4'd6,
        RES_READ_RELAYS  = 4'd7,
        RES_READ_STATUS  = 4'd8,
        RES_BAD_PARAMS   = 4'd9,
        RES_UNKNOWN      = 4'd10
    } res_t;

    typedef enum logic [2:0] {
        K_SEND,
        K_RELAY_ON,
        K_RELAY_OFF,
        K_ALL_OFF,
        K_READ_RELAYS,
        K_READ_STATUS
    } kind_t;

    // controller to datapath
    typedef struct packed {
        logic open_cmd;
        logic close_cmd;
        logic store_byte;
        logic scan_start;
        logic scan_step;
        logic acc_load;
        logic acc_shift;
        logic save_id;
        logic save_code;
        logic emit;
        res_t emit_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       byte_is_bang;
        logic       byte_is_nl;
        logic       is_open;
        logic       fill_zero;
        logic       fill_over;
        logic       fill_room;
        logic       out_busy;
        logic [7:0] ch;
        logic       ch_space;
        logic       ch_hex;
        logic       ch_zero;
        logic       ch_x;
        logic       acc_le_ff;
        logic       acc_lt_8;
    } dp_stat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end else begin
            v = c - 8'h37;
        end
        return v[3:0];
    endfunction

    function automatic res_t kind_to_res(input kind_t k);
        res_t r;
        unique case (k)
            K_SEND:        r = RES_SEND;
            K_RELAY_ON:    r = RES_RELAY_ON;
            K_RELAY_OFF:   r = RES_RELAY_OFF;
            K_ALL_OFF:     r = RES_ALL_OFF;
            K_READ_RELAYS: r = RES_READ_RELAYS;
            K_READ_STATUS: r = RES_READ_STATUS;
            default:       r = RES_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/scld_ram.sv
// ----------------------------------------------------------------------------
// scld_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/scld_dp.sv
// ----------------------------------------------------------------------------
// scld_dp
// Datapath: line buffer with fill count, scan pointer, hex accumulator,
// argument registers and the result output register.
// ----------------------------------------------------------------------------
module scld_dp #(
    parameter int MAX_LEN = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         s_rx_byte,
    input  scld_pkg::dp_cmd_t  cmd,
    output scld_pkg::dp_stat_t stat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_status,
    output logic [7:0]         m_target_id,
    output logic [7:0]         m_command_code,
    output logic [30:0]        m_parameter_word,
    output logic [2:0]         m_relay_number
);
    import scld_pkg::*;

    localparam int DEPTH  = MAX_LEN + 2;
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int AW     = $clog2(DEPTH);

    logic              open_reg, open_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [30:0]       acc_reg, acc_next;
    logic [7:0]        id_reg, id_next;
    logic [7:0]        code_reg, code_next;
    logic              m_valid_reg, m_valid_next;
    logic [3:0]        status_reg, status_next;
    logic [7:0]        target_reg, target_next;
    logic [7:0]        cmdcode_reg, cmdcode_next;
    logic [30:0]       param_reg, param_next;
    logic [2:0]        relay_reg, relay_next;
    logic [7:0]        rd_data;
    logic [7:0]        ch;
    logic [3:0]        hv;

    scld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_text (
        .aclk  (aclk),
        .we    (cmd.store_byte),
        .waddr (fill_reg[AW-1:0]),
        .wdata (s_rx_byte),
        .raddr (idx_next[AW-1:0]),
        .rdata (rd_data)
    );

    // bytes past the stored text read as NUL
    assign ch = (idx_reg < fill_reg) ? rd_data : 8'h00;
    assign hv = hex_val(ch);

    always_comb begin
        open_next = open_reg;
        fill_next = fill_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        id_next   = id_reg;
        code_next = code_reg;
        if (cmd.open_cmd) begin
            open_next = 1'b1;
            fill_next = '0;
        end
        if (cmd.close_cmd) begin
            open_next = 1'b0;
        end
        if (cmd.store_byte) begin
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.scan_start) begin
            idx_next = '0;
        end else if (cmd.scan_step) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.acc_load) begin
            acc_next = {27'd0, hv};
        end else if (cmd.acc_shift) begin
            if (acc_reg[30:27] != 4'd0) begin
                acc_next = SAT_VALUE;
            end else begin
                acc_next = {acc_reg[26:0], hv};
            end
        end
        if (cmd.save_id) begin
            id_next = acc_reg[7:0];
        end
        if (cmd.save_code) begin
            code_next = acc_reg[7:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg & ~m_ready;
        status_next  = status_reg;
        target_next  = target_reg;
        cmdcode_next = cmdcode_reg;
        param_next   = param_reg;
        relay_next   = relay_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
            status_next  = cmd.emit_status;
            target_next  = '0;
            cmdcode_next = '0;
            param_next   = '0;
            relay_next   = '0;
            unique case (cmd.emit_status) inside
                RES_SEND: begin
                    target_next  = id_reg;
                    cmdcode_next = code_reg;
                    param_next   = acc_reg;
                end
                RES_RELAY_ON, RES_RELAY_OFF: begin
                    target_next = id_reg;
                    relay_next  = acc_reg[2:0];
                end
                RES_ALL_OFF, RES_READ_RELAYS, RES_READ_STATUS: begin
                    target_next = acc_reg[7:0];
                end
                default: begin
                    target_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg    <= 1'b0;
            fill_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            open_reg    <= open_next;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg     <= acc_next;
        id_reg      <= id_next;
        code_reg    <= code_next;
        status_reg  <= status_next;
        target_reg  <= target_next;
        cmdcode_reg <= cmdcode_next;
        param_reg   <= param_next;
        relay_reg   <= relay_next;
    end

    always_comb begin
        stat.byte_is_bang = (s_rx_byte == CH_BANG);
        stat.byte_is_nl   = (s_rx_byte == CH_NL);
        stat.is_open      = open_reg;
        stat.fill_zero    = (fill_reg == '0);
        stat.fill_over    = (fill_reg > FILL_W'(MAX_LEN));
        stat.fill_room    = (fill_reg < FILL_W'(DEPTH));
        stat.out_busy     = m_valid_reg & ~m_ready;
        stat.ch           = ch;
        stat.ch_space     = is_space(ch);
        stat.ch_hex       = is_hex(ch);
        stat.ch_zero      = (ch == CH_ZERO);
        stat.ch_x         = (ch == CH_X_LO) || (ch == CH_X_UP);
        stat.acc_le_ff    = (acc_reg[30:8] == '0);
        stat.acc_lt_8     = (acc_reg[30:3] == '0);
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_target_id      = target_reg;
    assign m_command_code   = cmdcode_reg;
    assign m_parameter_word = param_reg;
    assign m_relay_number   = relay_reg;

    // scan never runs more than one position past the stored text
    a_scan_in_text: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan_step |-> idx_reg <= fill_reg)
        else $error("scan pointer past end of text");

endmodule

>>> hdl/scld_ctrl.sv
// ----------------------------------------------------------------------------
// scld_ctrl
// Controller: collects bytes into the line buffer and, on newline, walks the
// stored text one character per cycle to decode the command and arguments.
// ----------------------------------------------------------------------------
module scld_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  scld_pkg::dp_stat_t stat,
    output scld_pkg::dp_cmd_t  cmd
);
    import scld_pkg::*;

    state_t     state_reg, state_next;
    kind_t      kind_reg, kind_next;
    logic [1:0] arg_reg, arg_next;
    logic       accept;
    logic       last_arg;
    logic       val_ok;
    logic       go_on;
    res_t       end_res;
    logic       relay_op;

    assign s_ready = (state_reg == S_COLLECT) && (!stat.out_busy || !stat.byte_is_nl);
    assign accept  = s_valid && s_ready;

    assign relay_op = (stat.ch == CH_PLUS) || (stat.ch == CH_MINUS) ||
                      (stat.ch == CH_ZERO) || (stat.ch == CH_R) || (stat.ch == CH_S);

    always_comb begin
        unique case (kind_reg)
            K_SEND:                  last_arg = (arg_reg == 2'd2);
            K_RELAY_ON, K_RELAY_OFF: last_arg = (arg_reg == 2'd1);
            default:                 last_arg = (arg_reg == 2'd0);
        endcase
    end

    always_comb begin
        if (arg_reg == 2'd0) begin
            val_ok = stat.acc_le_ff;
        end else if (kind_reg == K_SEND) begin
            val_ok = (arg_reg == 2'd1) ? stat.acc_le_ff : 1'b1;
        end else begin
            val_ok = stat.acc_lt_8;
        end
    end

    // a number ended: continue only across whitespace to a further argument
    assign go_on   = val_ok && !last_arg && stat.ch_space;
    assign end_res = (val_ok && last_arg) ? kind_to_res(kind_reg) : RES_BAD_PARAMS;

    // next state
    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        arg_next   = arg_reg;
        unique case (state_reg)
            S_COLLECT: begin
                if (accept && stat.byte_is_nl && stat.is_open && !stat.fill_zero &&
                    !stat.fill_over) begin
                    state_next = S_CMD0;
                end
            end
            S_CMD0: begin
                arg_next = 2'd0;
                if (stat.ch == CH_S) begin
                    kind_next  = K_SEND;
                    state_next = S_SKIP;
                end else if (stat.ch == CH_R) begin
                    state_next = S_CMD1;
                end else begin
                    state_next = S_COLLECT;
                end
            end
            S_CMD1: begin
                state_next = relay_op ? S_SKIP : S_COLLECT;
                unique case (stat.ch)
                    CH_PLUS:  kind_next = K_RELAY_ON;
                    CH_MINUS: kind_next = K_RELAY_OFF;
                    CH_ZERO:  kind_next = K_ALL_OFF;
                    CH_R:     kind_next = K_READ_RELAYS;
                    CH_S:     kind_next = K_READ_STATUS;
                    default:  kind_next = kind_reg;
                endcase
            end
            S_SKIP: begin
                if (stat.ch_space) begin
                    state_next = S_SKIP;
                end else if (stat.ch_zero) begin
                    state_next = S_ZERO;
                end else if (stat.ch_hex) begin
                    state_next = S_DIGIT;
                end else begin
                    state_next = S_COLLECT;
                end
            end
            S_ZERO: begin
                if (stat.ch_x) begin
                    state_next = S_PREFIX;
                end else if (stat.ch_hex) begin
                    state_next = S_DIGIT;
                end else if (go_on) begin
                    state_next = S_SKIP;
                    arg_next   = arg_reg + 2'd1;
                end else begin
                    state_next = S_COLLECT;
                end
            end
            S_PREFIX: begin
                state_next = stat.ch_hex ? S_DIGIT : S_COLLECT;
            end
            S_DIGIT: begin
                if (stat.ch_hex) begin
                    state_next = S_DIGIT;
                end else if (go_on) begin
                    state_next = S_SKIP;
                    arg_next   = arg_reg + 2'd1;
                end else begin
                    state_next = S_COLLECT;
                end
            end
            default: begin
                state_next = S_COLLECT;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd             = '0;
        cmd.emit_status = RES_PROMPT;
        unique case (state_reg)
            S_COLLECT: begin
                if (accept) begin
                    if (stat.byte_is_bang) begin
                        cmd.open_cmd = 1'b1;
                    end else if (stat.byte_is_nl) begin
                        if (!stat.is_open) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = RES_PROMPT;
                        end else if (stat.fill_zero) begin
                            cmd.emit = 1'b0;
                        end else if (stat.fill_over) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = RES_TOO_LONG;
                            cmd.close_cmd   = 1'b1;
                        end else begin
                            cmd.close_cmd  = 1'b1;
                            cmd.scan_start = 1'b1;
                        end
                    end else begin
                        cmd.store_byte = stat.is_open && stat.fill_room;
                    end
                end
            end
            S_CMD0: begin
                cmd.scan_step = 1'b1;
                if (stat.ch == CH_QUERY) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = RES_HELP;
                end else if (stat.ch != CH_S && stat.ch != CH_R) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = RES_UNKNOWN;
                end
            end
            S_CMD1: begin
                cmd.scan_step = 1'b1;
                if (!relay_op) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = RES_UNKNOWN;
                end
            end
            S_SKIP: begin
                cmd.scan_step = 1'b1;
                if (stat.ch_hex) begin
                    cmd.acc_load = 1'b1;
                end else if (!stat.ch_space) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = RES_BAD_PARAMS;
                end
            end
            S_ZERO, S_DIGIT: begin
                cmd.scan_step = 1'b1;
                if (stat.ch_x && state_reg == S_ZERO) begin
                    cmd.acc_load = 1'b0;
                end else if (stat.ch_hex) begin
                    cmd.acc_shift = 1'b1;
                end else if (go_on) begin
                    cmd.save_id   = (arg_reg == 2'd0);
                    cmd.save_code = (arg_reg == 2'd1);
                end else begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = end_res;
                end
            end
            S_PREFIX: begin
                cmd.scan_step = 1'b1;
                if (stat.ch_hex) begin
                    cmd.acc_load = 1'b1;
                end else begin
                    // the x stops any further argument
                    cmd.emit        = 1'b1;
                    cmd.emit_status = end_res;
                end
            end
            default: begin
                cmd.emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_COLLECT;
            kind_reg  <= K_SEND;
            arg_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            arg_reg   <= arg_next;
        end
    end

    a_ready_only_collect: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_COLLECT)
        else $error("input ready outside collect state");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !stat.out_busy)
        else $error("result written over a pending word");

    a_newline_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && stat.byte_is_nl && stat.is_open && !stat.fill_zero && !stat.fill_over
        |=> state_reg == S_CMD0)
        else $error("newline on a stored command did not start the scan");

endmodule

>>> hdl/serial_command_line_decoder.sv
// ----------------------------------------------------------------------------
// serial_command_line_decoder
// Turns a stream of console bytes into decoded command words.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_rx_byte) takes one console byte per word.
// '!' opens a command, following bytes are stored (up to MAX_LEN + 2), and a
// newline closes it. The result channel (m_valid/m_ready) carries one decoded
// word per newline, except for a newline right after '!', which gives none.
// Ordinary bytes are taken as they come, with no wait between them. A newline
// that closes a stored command is decoded by walking the line buffer one
// character per cycle through the single read port, during which s_ready is
// low; m_valid rises the cycle after the last step.
// Newlines with no command open or with an over-long command raise m_valid
// the cycle after they are taken.
// The result sits in an output register: while it waits for m_ready, plain
// bytes are still taken, only a newline is held off until the word leaves.
// Reset (aresetn low, synchronous) closes any open command and drops a
// pending result; the line buffer is not cleared.
// ----------------------------------------------------------------------------
module serial_command_line_decoder #(
    parameter int MAX_LEN = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [7:0]  m_target_id,
    output logic [7:0]  m_command_code,
    output logic [30:0] m_parameter_word,
    output logic [2:0]  m_relay_number
);
    import scld_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    scld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scld_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_target_id      (m_target_id),
        .m_command_code   (m_command_code),
        .m_parameter_word (m_parameter_word),
        .m_relay_number   (m_relay_number)
    );

endmodule
